### design/tsr_pkg.sv
// Package for the text scrollback line ring.
// Holds request codes, payload structs, controller states and control structs.
// No dependencies.
`default_nettype none

package tsr_pkg;

  // Request codes carried in req_type
  localparam logic [2:0] REQ_WRITE     = 3'd0;
  localparam logic [2:0] REQ_NEWLINE   = 3'd1;
  localparam logic [2:0] REQ_PAGE_UP   = 3'd2;
  localparam logic [2:0] REQ_PAGE_DOWN = 3'd3;
  localparam logic [2:0] REQ_HOME      = 3'd4;
  localparam logic [2:0] REQ_READ      = 3'd5;

  // Blank cell and view limit
  localparam logic [7:0] BLANK_CHAR = 8'h20;
  localparam logic [7:0] BLANK_ATTR = 8'h0F;
  localparam logic [7:0] VIEW_CAP   = 8'hFF;

  typedef struct packed {
    logic [2:0] req_type;
    logic [6:0] column;
    logic [4:0] row;
    logic [7:0] cell_char;
    logic [7:0] cell_color;
  } req_t;

  typedef struct packed {
    logic [7:0] read_char;
    logic [7:0] read_color;
    logic       row_has_content;
    logic [7:0] view_offset;
    logic       at_newest;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_ADDR,
    ST_ACCESS,
    ST_SWEEP,
    ST_RESULT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load_item;
    logic decode;
    logic calc_addr;
    logic access;
    logic sweep;
    logic load_out;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [2:0] req_type;
    logic       sweep_last;
    logic       out_free;
  } status_t;

endpackage

`default_nettype wire

### design/tsr_ctrl.sv
// Controller state machine for the text scrollback line ring.
// Depends on tsr_pkg; drives tsr_dp through cmd_t and reads status_t.
`default_nettype none

module tsr_ctrl
  import tsr_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    req_valid,
  output logic    req_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;

  // State register; reset starts with the clearing sweep of line 0
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (status.sweep_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (req_valid) state_next = ST_DECODE;
      end
      ST_DECODE: begin
        if (status.req_type inside {REQ_WRITE, REQ_NEWLINE, REQ_READ}) begin
          state_next = ST_ADDR;
        end else begin
          state_next = ST_RESULT;
        end
      end
      ST_ADDR: begin
        if (status.req_type == REQ_NEWLINE) begin
          state_next = ST_SWEEP;
        end else begin
          state_next = ST_ACCESS;
        end
      end
      ST_ACCESS: state_next = ST_RESULT;
      ST_SWEEP: begin
        if (status.sweep_last) state_next = ST_RESULT;
      end
      ST_RESULT: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    req_ready     = (state == ST_IDLE);
    cmd.load_item = (state == ST_IDLE) && req_valid;
    cmd.decode    = (state == ST_DECODE);
    cmd.calc_addr = (state == ST_ADDR);
    cmd.access    = (state == ST_ACCESS);
    cmd.sweep     = (state == ST_CLEAR) || (state == ST_SWEEP);
    cmd.load_out  = (state == ST_RESULT) && status.out_free;
  end

endmodule

`default_nettype wire

### design/tsr_dp.sv
// Datapath for the text scrollback line ring: ring pointers, view offset,
// cell memory, sweep counter and output register. Depends on tsr_pkg.
`default_nettype none

module tsr_dp
  import tsr_pkg::*;
#(
  parameter int LINES_KEPT   = 256,
  parameter int LINE_WIDTH   = 80,
  parameter int CONTENT_ROWS = 21
) (
  input  logic    clk,
  input  logic    rst,
  input  req_t    req,
  output logic    rsp_valid,
  input  logic    rsp_ready,
  output rsp_t    rsp,
  input  cmd_t    cmd,
  output status_t status
);

  localparam int LINE_W = $clog2(LINES_KEPT);
  localparam int WRAP_W = LINE_W + 1;
  localparam int HELD_W = $clog2(LINES_KEPT + 1);
  localparam int DEPTH  = LINES_KEPT * LINE_WIDTH;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(LINE_WIDTH);
  localparam int CMP_W  = (HELD_W > 10) ? HELD_W : 10;
  localparam int HALF   = CONTENT_ROWS / 2;

  req_t              item;
  logic [LINE_W-1:0] newest_line;
  logic [LINE_W-1:0] newest_next;
  logic [HELD_W-1:0] lines_held;
  logic [7:0]        scroll_back;

  logic [LINE_W-1:0] line_sel;
  logic              do_write;
  logic              hit;
  logic              col_ok;
  logic [ADDR_W-1:0] addr;
  logic [CNT_W-1:0]  cnt;

  logic [15:0]       mem [DEPTH];
  logic [15:0]       rdata;
  logic              mem_we;
  logic [15:0]       mem_wdata;

  logic [CMP_W-1:0]  held_x;
  logic [CMP_W-1:0]  lim_x;
  logic [CMP_W-1:0]  back;
  logic [7:0]        lim;
  logic [8:0]        up_sum;
  logic [7:0]        sb_up;
  logic [7:0]        sb_down;
  logic              row_ok;
  logic              col_in;
  logic              hit_now;
  logic [LINE_W-1:0] back_lo;
  logic [WRAP_W-1:0] wrap_sum;
  logic [LINE_W-1:0] read_line;
  logic              sweep_last;
  rsp_t              rsp_next;

  // Hold the accepted transaction
  always_ff @(posedge clk) begin
    if (cmd.load_item) item <= req;
  end

  // Scroll limits: page up stops at held lines minus one screen, capped
  assign held_x  = CMP_W'(lines_held);
  assign lim_x   = (held_x > CMP_W'(CONTENT_ROWS)) ? held_x - CMP_W'(CONTENT_ROWS) : '0;
  assign lim     = (lim_x > CMP_W'(VIEW_CAP)) ? VIEW_CAP : lim_x[7:0];
  assign up_sum  = {1'b0, scroll_back} + 9'(HALF);
  assign sb_up   = (scroll_back < lim) ?
                   ((up_sum > {1'b0, lim}) ? lim : up_sum[7:0]) : scroll_back;
  assign sb_down = (scroll_back > 8'(HALF)) ? scroll_back - 8'(HALF) : 8'd0;

  // Map a content row to a ring line; a hit implies back < LINES_KEPT
  assign row_ok    = 7'(item.row) < 7'(CONTENT_ROWS);
  assign col_in    = 8'(item.column) < 8'(LINE_WIDTH);
  assign back      = CMP_W'(scroll_back) + CMP_W'(CONTENT_ROWS - 1) - CMP_W'(item.row);
  assign hit_now   = (item.req_type == REQ_READ) && row_ok && (back < held_x);
  assign back_lo   = back[LINE_W-1:0];
  assign wrap_sum  = {1'b0, newest_line} + WRAP_W'(LINES_KEPT) - {1'b0, back_lo};
  assign read_line = (back_lo > newest_line) ? wrap_sum[LINE_W-1:0]
                                             : newest_line - back_lo;

  assign newest_next = (newest_line == LINE_W'(LINES_KEPT - 1)) ? '0 : newest_line + 1'b1;

  // Ring pointer, line count and view offset
  always_ff @(posedge clk) begin
    if (rst) begin
      newest_line <= '0;
      lines_held  <= '0;
      scroll_back <= '0;
    end else if (cmd.decode) begin
      case (item.req_type)
        REQ_WRITE: begin
          if (scroll_back == 8'd0 && lines_held == '0) lines_held <= HELD_W'(1);
        end
        REQ_NEWLINE: begin
          newest_line <= newest_next;
          if (lines_held < HELD_W'(LINES_KEPT)) lines_held <= lines_held + 1'b1;
        end
        REQ_PAGE_UP:   scroll_back <= sb_up;
        REQ_PAGE_DOWN: scroll_back <= sb_down;
        REQ_HOME:      scroll_back <= '0;
        default: ;
      endcase
    end
  end

  // Latch the decoded target line and flags
  always_ff @(posedge clk) begin
    if (cmd.decode) begin
      do_write <= (item.req_type == REQ_WRITE) && (scroll_back == 8'd0) && col_in;
      hit      <= hit_now;
      col_ok   <= col_in;
      case (item.req_type)
        REQ_NEWLINE: line_sel <= newest_next;
        REQ_READ:    line_sel <= read_line;
        default:     line_sel <= newest_line;
      endcase
    end
  end

  // Cell address and sweep counter; reset points at the start of line 0
  assign sweep_last = (cnt == CNT_W'(LINE_WIDTH - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      addr <= '0;
      cnt  <= '0;
    end else if (cmd.calc_addr) begin
      addr <= ADDR_W'(line_sel) * ADDR_W'(LINE_WIDTH)
            + ((item.req_type == REQ_NEWLINE) ? '0 : ADDR_W'(item.column));
    end else if (cmd.sweep) begin
      addr <= addr + 1'b1;
      cnt  <= sweep_last ? '0 : cnt + 1'b1;
    end
  end

  // Cell memory: character in the high byte, attribute in the low byte
  assign mem_we    = cmd.sweep || (cmd.access && do_write);
  assign mem_wdata = cmd.sweep ? {BLANK_CHAR, BLANK_ATTR} : {item.cell_char, item.cell_color};

  always_ff @(posedge clk) begin
    if (mem_we) mem[addr] <= mem_wdata;
    rdata <= mem[addr];
  end

  // Build the result
  always_comb begin
    rsp_next.read_char       = (hit && col_ok) ? rdata[15:8] : BLANK_CHAR;
    rsp_next.read_color      = (hit && col_ok) ? rdata[7:0]  : BLANK_ATTR;
    rsp_next.row_has_content = hit;
    rsp_next.view_offset     = scroll_back;
    rsp_next.at_newest       = (scroll_back == 8'd0);
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.load_out) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) rsp <= rsp_next;
  end

  assign status.req_type   = item.req_type;
  assign status.sweep_last = sweep_last;
  assign status.out_free   = !rsp_valid || rsp_ready;

  // The view never reaches lines that are not held
  a_view_in_range: assert property (@(posedge clk) disable iff (rst)
    scroll_back <= lim)
    else $error("view offset beyond held lines");

  // Line count saturates at ring depth
  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    lines_held <= HELD_W'(LINES_KEPT))
    else $error("line count above ring depth");

  // A result is loaded only into a free output register
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!rsp_valid || rsp_ready))
    else $error("result overwrote a pending transaction");

  // A new line moves the ring pointer by exactly one
  a_ring_step: assert property (@(posedge clk) disable iff (rst)
    (cmd.decode && item.req_type == REQ_NEWLINE) |=> (newest_line == $past(newest_next)))
    else $error("ring pointer did not advance");

endmodule

`default_nettype wire

### design/text_scrollback_line_ring.sv
// Top level of the text scrollback line ring: controller plus datapath.
// Depends on tsr_pkg, tsr_ctrl and tsr_dp.
//
//   channel   direction   handshake              payload
//   req       in          req_valid / req_ready  req_t: type, column, row, char, color
//   rsp       out         rsp_valid / rsp_ready  rsp_t: char, color, content, offset, newest
//
// Read and write pass through decode, address, access and result states; scroll
// requests through decode and result; a new line through decode, address, sweep
// and result: its sweep blanks one cell per cycle on the single memory write port.
// After reset, line 0 is blanked before req_ready rises; other lines are blanked as
// the ring reaches them. A new request is taken while the previous result waits in
// the output register; a finished result waits for that register to drain.
`default_nettype none

module text_scrollback_line_ring
  import tsr_pkg::*;
#(
  parameter int LINES_KEPT   = 256,
  parameter int LINE_WIDTH   = 80,
  parameter int CONTENT_ROWS = 21
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  cmd_t    cmd;
  status_t status;

  tsr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .status    (status),
    .cmd       (cmd)
  );

  tsr_dp #(
    .LINES_KEPT   (LINES_KEPT),
    .LINE_WIDTH   (LINE_WIDTH),
    .CONTENT_ROWS (CONTENT_ROWS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

`default_nettype wire

### tb/text_scrollback_line_ring_test.sv
// Testbench for text_scrollback_line_ring: random and directed terminal requests,
// each result checked against an in-bench scrollback predictor.
// Depends on tsr_pkg and the text_scrollback_line_ring RTL.
`default_nettype none

module text_scrollback_line_ring_test
  import tsr_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LINES_KEPT   = 256;
  localparam int LINE_WIDTH   = 80;
  localparam int CONTENT_ROWS = 21;
  localparam int HALF_PAGE    = CONTENT_ROWS / 2;
  localparam int RANDOM_ITEMS = 1200;
  localparam int DRAIN_CYCLES = 200;
  localparam int IDLE_LIMIT   = 3000;
  localparam int LONG_HOLD    = 500;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  // Handshakes seen at the last rising edge
  logic req_taken = 1'b0;
  logic rsp_taken = 1'b0;

  // Predictor state: screen memory, write line, stored line count, view offset
  logic [7:0] glyph_mem [0:LINES_KEPT*LINE_WIDTH-1];
  logic [7:0] attr_mem  [0:LINES_KEPT*LINE_WIDTH-1];
  int write_line;
  int line_count;
  int view_back;

  req_t queued_reqs [$];
  rsp_t due_results [$];

  int mismatches = 0;
  int results_checked = 0;
  int sent = 0;
  int send_gap = 0;
  int hold_cycles = 0;
  logic held_off = 1'b0;
  int idle_cycles = 0;
  int newline_count = 0;
  int deepest_view = 0;

  text_scrollback_line_ring #(
    .LINES_KEPT  (LINES_KEPT),
    .LINE_WIDTH  (LINE_WIDTH),
    .CONTENT_ROWS(CONTENT_ROWS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  always #10 clk = ~clk;

  // Apply one request to the predictor and return the result it should produce
  function automatic rsp_t scrollback_predict(req_t r);
    rsp_t res;
    int lim;
    int back;
    int line;
    int base;
    res.read_char       = BLANK_CHAR;
    res.read_color      = BLANK_ATTR;
    res.row_has_content = 1'b0;
    case (r.req_type)
      REQ_WRITE: begin
        // writes land only when the view sits on the newest line
        if (view_back == 0) begin
          if (line_count == 0) line_count = 1;
          if (int'(r.column) < LINE_WIDTH) begin
            glyph_mem[write_line*LINE_WIDTH + int'(r.column)] = r.cell_char;
            attr_mem[write_line*LINE_WIDTH + int'(r.column)]  = r.cell_color;
          end
        end
      end
      REQ_NEWLINE: begin
        write_line = (write_line + 1) % LINES_KEPT;
        if (line_count < LINES_KEPT) line_count++;
        base = write_line * LINE_WIDTH;
        for (int i = 0; i < LINE_WIDTH; i++) begin
          glyph_mem[base + i] = BLANK_CHAR;
          attr_mem[base + i]  = BLANK_ATTR;
        end
      end
      REQ_PAGE_UP: begin
        lim = (line_count > CONTENT_ROWS) ? line_count - CONTENT_ROWS : 0;
        if (lim > int'(VIEW_CAP)) lim = int'(VIEW_CAP);
        if (view_back < lim) begin
          view_back += HALF_PAGE;
          if (view_back > lim) view_back = lim;
        end
      end
      REQ_PAGE_DOWN: begin
        if (view_back > 0) view_back = (view_back > HALF_PAGE) ? view_back - HALF_PAGE : 0;
      end
      REQ_HOME: begin
        view_back = 0;
      end
      REQ_READ: begin
        if (int'(r.row) < CONTENT_ROWS) begin
          back = view_back + CONTENT_ROWS - 1 - int'(r.row);
          if (back < line_count) begin
            line = (write_line + LINES_KEPT - (back % LINES_KEPT)) % LINES_KEPT;
            res.row_has_content = 1'b1;
            if (int'(r.column) < LINE_WIDTH) begin
              res.read_char  = glyph_mem[line*LINE_WIDTH + int'(r.column)];
              res.read_color = attr_mem[line*LINE_WIDTH + int'(r.column)];
            end
          end
        end
      end
      default: ;
    endcase
    res.view_offset = view_back[7:0];
    res.at_newest   = (view_back == 0);
    return res;
  endfunction

  function automatic void queue_req(logic [2:0] kind, int col, int row, int ch, int color);
    req_t r;
    r.req_type   = kind;
    r.column     = 7'(col);
    r.row        = 5'(row);
    r.cell_char  = 8'(ch);
    r.cell_color = 8'(color);
    queued_reqs.push_back(r);
    if (kind == REQ_NEWLINE) newline_count++;
  endfunction

  // Mostly the first few columns so reads hit written cells, sometimes past the line end
  function automatic int pick_column();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 6) return $urandom_range(0, 15);
    if (roll < 9) return $urandom_range(0, LINE_WIDTH - 1);
    return $urandom_range(0, 127);
  endfunction

  // Idle length: mostly short, a few long, with stretches at full rate
  function automatic int pick_gap(int seq);
    int roll;
    roll = $urandom_range(0, 99);
    if ((seq / 80) % 6 == 3) return 0;
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 20);
    return $urandom_range(40, 150);
  endfunction

  // Drive requests from the queue; hold each one until it is taken
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_taken) begin
      if (send_gap > 0) begin
        req_valid <= 1'b0;
        send_gap--;
      end else if (queued_reqs.size() != 0) begin
        req       <= queued_reqs.pop_front();
        req_valid <= 1'b1;
        send_gap = pick_gap(sent);
        sent++;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Response side: random stalls plus one long hold-off to back the block up
  always @(negedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else if (!held_off && results_checked >= 150) begin
      held_off = 1'b1;
      hold_cycles = LONG_HOLD;
      rsp_ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      rsp_ready <= 1'b0;
      hold_cycles--;
    end else begin
      if (rsp_taken) hold_cycles = pick_gap(results_checked);
      if (hold_cycles > 0) begin
        rsp_ready <= 1'b0;
        hold_cycles--;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  // Predict on each accepted request, check each accepted result
  always @(posedge clk) begin
    rsp_t want;
    req_taken <= req_valid && req_ready && !rst;
    rsp_taken <= rsp_valid && rsp_ready && !rst;
    if (!rst) begin
      if (rsp_valid && rsp_ready) begin
        results_checked <= results_checked + 1;
        if (due_results.size() == 0) begin
          $error("result with no request outstanding: %p", rsp);
          mismatches++;
        end else begin
          want = due_results.pop_front();
          if (rsp.read_char !== want.read_char) begin
            $error("read_char: expected %0h, got %0h", want.read_char, rsp.read_char);
            mismatches++;
          end
          if (rsp.read_color !== want.read_color) begin
            $error("read_color: expected %0h, got %0h", want.read_color, rsp.read_color);
            mismatches++;
          end
          if (rsp.row_has_content !== want.row_has_content) begin
            $error("row_has_content: expected %0d, got %0d",
                   want.row_has_content, rsp.row_has_content);
            mismatches++;
          end
          if (rsp.view_offset !== want.view_offset) begin
            $error("view_offset: expected %0d, got %0d", want.view_offset, rsp.view_offset);
            mismatches++;
          end
          if (rsp.at_newest !== want.at_newest) begin
            $error("at_newest: expected %0d, got %0d", want.at_newest, rsp.at_newest);
            mismatches++;
          end
        end
      end
      if (req_valid && req_ready) begin
        want = scrollback_predict(req);
        due_results.push_back(want);
        if (int'(want.view_offset) > deepest_view) deepest_view = int'(want.view_offset);
      end
    end
  end

  // Stop a hung run: count cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout: no transaction for %0d cycles, %0d results outstanding",
                 idle_cycles, due_results.size());
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    int roll;
    int n;
    for (int i = 0; i < LINES_KEPT*LINE_WIDTH; i++) begin
      glyph_mem[i] = BLANK_CHAR;
      attr_mem[i]  = BLANK_ATTR;
    end
    write_line = 0;
    line_count = 0;
    view_back  = 0;

    // Directed: empty store, field extremes, bad rows and columns, unknown codes
    queue_req(REQ_READ,      0,   20, 8'h41, 8'h00);
    queue_req(REQ_PAGE_UP,   0,    0, 0,     0);
    queue_req(REQ_PAGE_DOWN, 0,    0, 0,     0);
    queue_req(REQ_WRITE,     0,    0, 8'h00, 8'h00);
    queue_req(REQ_WRITE,     79,  31, 8'hFF, 8'hFF);
    queue_req(REQ_WRITE,     127,  0, 8'hAA, 8'h55);
    queue_req(REQ_WRITE,     80,   0, 8'h12, 8'h34);
    queue_req(REQ_READ,      0,   20, 0,     0);
    queue_req(REQ_READ,      79,  20, 0,     0);
    queue_req(REQ_READ,      127, 20, 0,     0);
    queue_req(REQ_READ,      0,   19, 0,     0);
    queue_req(REQ_READ,      5,   31, 0,     0);
    queue_req(REQ_READ,      0,   21, 0,     0);
    queue_req(3'd6,          127, 31, 8'hFF, 8'hFF);
    queue_req(3'd7,          0,    0, 8'h00, 8'h00);
    queue_req(REQ_NEWLINE,   0,    0, 0,     0);
    queue_req(REQ_READ,      79,  19, 0,     0);
    queue_req(REQ_READ,      79,  20, 0,     0);
    queue_req(REQ_HOME,      0,    0, 0,     0);
    queue_req(REQ_PAGE_UP,   0,    0, 0,     0);
    queue_req(REQ_READ,      0,    0, 0,     0);

    // Random: single requests mixed with line-fill and scroll-back sequences
    while (queued_reqs.size() < RANDOM_ITEMS) begin
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        // fill a fresh line and read it back
        queue_req(REQ_HOME, $urandom, $urandom, $urandom, $urandom);
        queue_req(REQ_NEWLINE, $urandom, $urandom, $urandom, $urandom);
        n = $urandom_range(1, 6);
        repeat (n) queue_req(REQ_WRITE, pick_column(), $urandom, $urandom, $urandom);
        repeat (2) queue_req(REQ_READ, pick_column(), $urandom_range(19, 20), $urandom, $urandom);
      end else if (roll < 7) begin
        // scroll back, look around, come back
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 25) : $urandom_range(1, 6);
        repeat (n) queue_req(REQ_PAGE_UP, $urandom, $urandom, $urandom, $urandom);
        repeat (3) queue_req(REQ_READ, pick_column(), $urandom_range(0, 20), $urandom, $urandom);
        queue_req(REQ_WRITE, pick_column(), $urandom, $urandom, $urandom);
        n = $urandom_range(0, 3);
        repeat (n) queue_req(REQ_PAGE_DOWN, $urandom, $urandom, $urandom, $urandom);
        queue_req(REQ_READ, pick_column(), $urandom_range(0, 20), $urandom, $urandom);
        queue_req(REQ_HOME, $urandom, $urandom, $urandom, $urandom);
      end else if (roll < 32) begin
        queue_req(REQ_WRITE, pick_column(), $urandom, $urandom, $urandom);
      end else if (roll < 64) begin
        queue_req(REQ_NEWLINE, $urandom, $urandom, $urandom, $urandom);
      end else if (roll < 70) begin
        queue_req(REQ_PAGE_UP, $urandom, $urandom, $urandom, $urandom);
      end else if (roll < 75) begin
        queue_req(REQ_PAGE_DOWN, $urandom, $urandom, $urandom, $urandom);
      end else if (roll < 80) begin
        queue_req(REQ_HOME, $urandom, $urandom, $urandom, $urandom);
      end else if (roll < 98) begin
        queue_req(REQ_READ, pick_column(),
                  ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 20),
                  $urandom, $urandom);
      end else begin
        queue_req(3'($urandom_range(6, 7)), $urandom, $urandom, $urandom, $urandom);
      end
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Wait for the queue to drain and every result to come back
    while (queued_reqs.size() != 0 || req_valid || due_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Sent %0d requests (%0d new lines), checked %0d results", sent, newline_count,
             results_checked);
    $display("Deepest scroll-back %0d, lines stored at end %0d", deepest_view, line_count);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
